// File: rtl/core/bfa_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the bitmap frame allocator.
// No dependencies; bfa_div and the top level refer to it by scoped names.
package bfa_pkg;

  // Bitmap geometry: the map is stored as words in a synchronous RAM
  localparam int NUM_FRAMES = 32;
  localparam int WORD_W     = 8;
  localparam int NUM_WORDS  = NUM_FRAMES / WORD_W;
  localparam int WADDR_W    = $clog2(NUM_WORDS);
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int FRAME_W    = 5;
  localparam int COUNT_W    = 6;
  localparam int WCNT_W     = $clog2(WORD_W + 1);
  localparam int SEED_W     = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [COUNT_W-1:0] RESET_FRAMES = 6'd32;
  localparam logic [SEED_W-1:0]  RESET_SEED   = 16'd1;
  localparam logic [SEED_W-1:0]  LFSR_TAPS    = 16'hB400;

  // Request command codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Allocation policy codes; the spare code behaves as first free
  localparam logic [1:0] POL_FIRST  = 2'd0;
  localparam logic [1:0] POL_LAST   = 2'd1;
  localparam logic [1:0] POL_RANDOM = 2'd2;
  localparam logic [1:0] POL_SPARE  = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NONE_FREE = 2'd1;
  localparam logic [1:0] STAT_RANGE     = 2'd2;
  localparam logic [1:0] STAT_NOT_USED  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd2;

  // Divider request and response between control and the modulo unit
  typedef struct packed {
    logic                start;
    logic [SEED_W-1:0]   dividend;
    logic [COUNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [COUNT_W-1:0]  rem;
  } div_rsp_t;

endpackage

// File: rtl/core/bfa_req_if.sv
`timescale 1ns / 1ps
// Request channel of the bitmap frame allocator: valid/ready plus request fields.
// Depends on nothing.
interface bfa_req_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic       use_override;
  logic [1:0] policy_choice;
  logic [4:0] release_index;

  modport source (output valid, command, use_override, policy_choice, release_index,
                  input ready);
  modport sink   (input valid, command, use_override, policy_choice, release_index,
                  output ready);
endinterface

// File: rtl/core/bfa_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the bitmap frame allocator: valid/ready plus result fields.
// Depends on nothing.
interface bfa_rsp_if;
  logic       valid;
  logic       ready;
  logic [4:0] frame_number;
  logic       granted;
  logic [1:0] status;
  logic [5:0] free_frames;

  modport source (output valid, frame_number, granted, status, free_frames,
                  input ready);
  modport sink   (input valid, frame_number, granted, status, free_frames,
                  output ready);
endinterface

// File: rtl/core/bfa_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: valid/ready, register index and write data.
// Depends on nothing.
interface bfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/bfa_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
module bfa_ram #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bfa_div.sv
`timescale 1ns / 1ps
// Restoring modulo unit: remainder of the LFSR value by the free count, one bit per cycle.
// Depends on bfa_pkg.
module bfa_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfa_pkg::div_req_t  req_i,
  output bfa_pkg::div_rsp_t  rsp_o
);

  localparam int CNT_W = $clog2(bfa_pkg::SEED_W);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [bfa_pkg::SEED_W-1:0]   dvd_q, dvd_d;
  logic [bfa_pkg::COUNT_W-1:0]  rem_q, rem_d;
  logic [bfa_pkg::COUNT_W-1:0]  dsr_q, dsr_d;
  logic [bfa_pkg::COUNT_W:0]    trial;
  logic [bfa_pkg::COUNT_W:0]    diff;

  // Shift in the next dividend bit and subtract when it fits
  assign trial = {rem_q, dvd_q[bfa_pkg::SEED_W-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[bfa_pkg::SEED_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff[bfa_pkg::COUNT_W-1:0];
      end else begin
        rem_d = trial[bfa_pkg::COUNT_W-1:0];
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(bfa_pkg::SEED_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      dvd_q  <= dvd_d;
      rem_q  <= rem_d;
      dsr_q  <= dsr_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// File: rtl/core/bitmap_frame_allocator_unit.sv
`timescale 1ns / 1ps
// Top level of the bitmap frame allocator: control sequencer around the bitmap RAM.
// Depends on bfa_pkg, the three channel interfaces, bfa_ram and bfa_div.

// The used/free bitmap sits in a small RAM of 8-bit words (4 words for 32 frames) and
// is walked one word at a time; each word takes a read issue state, then an
// evaluate and write-back state. After reset a clearing pass zeroes the map
// before the first request is taken. A release reads, clears and writes back its
// word; an allocation that finds no free frame or a release out of range goes
// straight to the result. First-free and last-free allocations scan words from the
// low and the high end. A random allocation first runs the bit-serial modulo unit,
// then a scan from the low end. A write of frames_in_use starts a recount of the
// free frames, during which requests wait. A finished result sits in an output
// register, so the next request is taken while it is still unclaimed.
module bitmap_frame_allocator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfa_req_if.sink    req_i,
  bfa_rsp_if.source  rsp_o,
  bfa_cfg_if.sink    cfg_i
);

  localparam int W   = bfa_pkg::WORD_W;
  localparam int AW  = bfa_pkg::WADDR_W;
  localparam int BW  = bfa_pkg::BIT_W;
  localparam int CW  = bfa_pkg::COUNT_W;
  localparam int FW  = bfa_pkg::FRAME_W;
  localparam int SW  = bfa_pkg::SEED_W;
  localparam int NCW = bfa_pkg::WCNT_W;
  localparam logic [AW-1:0] LAST_WORD = AW'(bfa_pkg::NUM_WORDS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_RD,
    S_EV,
    S_RESULT
  } state_e;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_RELEASE,
    OP_RECOUNT
  } op_e;

  // Galois LFSR, shift right with taps on the bit shifted out
  function automatic logic [SW-1:0] lfsr_next(input logic [SW-1:0] v);
    logic [SW-1:0] r;
    r = v >> 1;
    if (v[0]) begin
      r = r ^ bfa_pkg::LFSR_TAPS;
    end
    return r;
  endfunction

  // Bits of one word that fall below the managed frame count
  function automatic logic [W-1:0] word_mask(input logic [AW-1:0] w,
                                             input logic [CW-1:0] n);
    logic [W-1:0] m;
    logic [FW-1:0] idx;
    for (int b = 0; b < W; b++) begin
      idx  = {w, BW'(b)};
      m[b] = ({1'b0, idx} < n);
    end
    return m;
  endfunction

  function automatic logic [NCW-1:0] popcount(input logic [W-1:0] f);
    logic [NCW-1:0] c;
    c = '0;
    for (int b = 0; b < W; b++) begin
      c = c + NCW'(f[b]);
    end
    return c;
  endfunction

  function automatic logic [BW-1:0] lowest(input logic [W-1:0] f);
    logic [BW-1:0] r;
    r = '0;
    for (int b = W - 1; b >= 0; b--) begin
      if (f[b]) begin
        r = BW'(b);
      end
    end
    return r;
  endfunction

  function automatic logic [BW-1:0] highest(input logic [W-1:0] f);
    logic [BW-1:0] r;
    r = '0;
    for (int b = 0; b < W; b++) begin
      if (f[b]) begin
        r = BW'(b);
      end
    end
    return r;
  endfunction

  // Position of the k-th set bit, counting from zero at the low end
  function automatic logic [BW-1:0] kth_set(input logic [W-1:0] f, input logic [BW-1:0] k);
    logic [BW-1:0]  r;
    logic [NCW-1:0] seen;
    r    = '0;
    seen = '0;
    for (int b = 0; b < W; b++) begin
      if (f[b]) begin
        if (seen == {1'b0, k}) begin
          r = BW'(b);
        end
        seen = seen + NCW'(1);
      end
    end
    return r;
  endfunction

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [1:0]        pol_q, pol_d;
  logic [BW-1:0]     bitsel_q, bitsel_d;
  logic [CW-1:0]     k_q, k_d;
  logic [CW-1:0]     acc_q, acc_d;
  logic [CW-1:0]     free_q, free_d;
  logic [SW-1:0]     lfsr_q, lfsr_d;
  logic [CW-1:0]     fiu_q, fiu_d;
  logic [1:0]        dpol_q, dpol_d;
  logic              pend_q, pend_d;
  logic [FW-1:0]     res_frame_q, res_frame_d;
  logic              res_granted_q, res_granted_d;
  logic [1:0]        res_status_q, res_status_d;
  logic              rsp_valid_q, rsp_valid_d;
  logic [FW-1:0]     rsp_frame_q, rsp_frame_d;
  logic              rsp_granted_q, rsp_granted_d;
  logic [1:0]        rsp_status_q, rsp_status_d;
  logic [CW-1:0]     rsp_free_q, rsp_free_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [W-1:0]      ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [W-1:0]      ram_rdata;

  bfa_pkg::div_req_t div_req;
  bfa_pkg::div_rsp_t div_rsp;
  logic              div_start;

  logic [CW-1:0]     managed;
  logic [W-1:0]      free_bits;
  logic [NCW-1:0]    free_cnt;
  logic [CW-1:0]     acc_sum;
  logic [1:0]        req_pol;
  logic [SW-1:0]     lfsr_stepped;
  logic              hit;
  logic [BW-1:0]     hit_bit;

  bfa_ram #(
    .DEPTH (bfa_pkg::NUM_WORDS),
    .WIDTH (W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bfa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Managed frame count, clamped to the bitmap size
  assign managed = (fiu_q > CW'(bfa_pkg::NUM_FRAMES)) ? CW'(bfa_pkg::NUM_FRAMES) : fiu_q;

  // Free managed frames in the word just read
  assign free_bits = ~ram_rdata & word_mask(ptr_q, managed);
  assign free_cnt  = popcount(free_bits);
  assign acc_sum   = acc_q + CW'(free_cnt);

  assign lfsr_stepped = lfsr_next(lfsr_q);

  // Effective policy of the incoming request; code three acts as first free
  always_comb begin
    req_pol = req_i.use_override ? req_i.policy_choice : dpol_q;
    if (req_pol != bfa_pkg::POL_LAST && req_pol != bfa_pkg::POL_RANDOM) begin
      req_pol = bfa_pkg::POL_FIRST;
    end
  end

  // Pick within the current word by the active policy
  always_comb begin
    hit     = (free_bits != '0);
    hit_bit = lowest(free_bits);
    if (pol_q == bfa_pkg::POL_LAST) begin
      hit_bit = highest(free_bits);
    end else if (pol_q == bfa_pkg::POL_RANDOM) begin
      hit     = (k_q < CW'(free_cnt));
      hit_bit = kth_set(free_bits, k_q[BW-1:0]);
    end
  end

  assign div_req.start    = div_start;
  assign div_req.dividend = lfsr_stepped;
  assign div_req.divisor  = free_q;

  assign req_i.ready = (state_q == S_IDLE) && !pend_q;
  assign cfg_i.ready = 1'b1;

  // Sequencer next state
  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    ptr_d         = ptr_q;
    pol_d         = pol_q;
    bitsel_d      = bitsel_q;
    k_d           = k_q;
    acc_d         = acc_q;
    free_d        = free_q;
    lfsr_d        = lfsr_q;
    fiu_d         = fiu_q;
    dpol_d        = dpol_q;
    pend_d        = pend_q;
    res_frame_d   = res_frame_q;
    res_granted_d = res_granted_q;
    res_status_d  = res_status_q;
    rsp_valid_d   = rsp_valid_q;
    rsp_frame_d   = rsp_frame_q;
    rsp_granted_d = rsp_granted_q;
    rsp_status_d  = rsp_status_q;
    rsp_free_d    = rsp_free_q;
    ram_we        = 1'b0;
    ram_waddr     = ptr_q;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = ptr_q;
    div_start     = 1'b0;

    // Drop the output beat once taken
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        ptr_d     = ptr_q + AW'(1);
        if (ptr_q == LAST_WORD) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (pend_q) begin
          pend_d  = 1'b0;
          op_d    = OP_RECOUNT;
          ptr_d   = '0;
          acc_d   = '0;
          state_d = S_RD;
        end else if (req_i.valid) begin
          res_frame_d   = '0;
          res_granted_d = 1'b0;
          res_status_d  = bfa_pkg::STAT_OK;
          if (req_i.command == bfa_pkg::CMD_ALLOC) begin
            op_d  = OP_ALLOC;
            pol_d = req_pol;
            if (free_q == '0) begin
              res_status_d = bfa_pkg::STAT_NONE_FREE;
              state_d      = S_RESULT;
            end else if (req_pol == bfa_pkg::POL_LAST) begin
              ptr_d   = LAST_WORD;
              state_d = S_RD;
            end else if (req_pol == bfa_pkg::POL_RANDOM) begin
              lfsr_d    = lfsr_stepped;
              div_start = 1'b1;
              state_d   = S_DIV;
            end else begin
              ptr_d   = '0;
              state_d = S_RD;
            end
          end else begin
            op_d = OP_RELEASE;
            if ({1'b0, req_i.release_index} >= managed) begin
              res_status_d = bfa_pkg::STAT_RANGE;
              state_d      = S_RESULT;
            end else begin
              ptr_d    = req_i.release_index[FW-1:BW];
              bitsel_d = req_i.release_index[BW-1:0];
              state_d  = S_RD;
            end
          end
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          k_d     = div_rsp.rem;
          ptr_d   = '0;
          state_d = S_RD;
        end
      end

      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_EV;
      end

      S_EV: begin
        case (op_q)
          OP_RECOUNT: begin
            if (ptr_q == LAST_WORD) begin
              free_d  = acc_sum;
              ptr_d   = '0;
              state_d = S_IDLE;
            end else begin
              acc_d   = acc_sum;
              ptr_d   = ptr_q + AW'(1);
              state_d = S_RD;
            end
          end
          OP_RELEASE: begin
            if (!ram_rdata[bitsel_q]) begin
              res_status_d = bfa_pkg::STAT_NOT_USED;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata & ~(W'(1) << bitsel_q);
              free_d    = free_q + CW'(1);
            end
            state_d = S_RESULT;
          end
          OP_ALLOC: begin
            if (hit) begin
              ram_we        = 1'b1;
              ram_wdata     = ram_rdata | (W'(1) << hit_bit);
              free_d        = free_q - CW'(1);
              res_frame_d   = {ptr_q, hit_bit};
              res_granted_d = 1'b1;
              state_d       = S_RESULT;
            end else begin
              if (pol_q == bfa_pkg::POL_RANDOM) begin
                k_d = k_q - CW'(free_cnt);
              end
              if (pol_q == bfa_pkg::POL_LAST) begin
                ptr_d = ptr_q - AW'(1);
              end else begin
                ptr_d = ptr_q + AW'(1);
              end
              state_d = S_RD;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_RESULT: begin
        // Load the output register once it is free or being emptied
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d   = 1'b1;
          rsp_frame_d   = res_frame_q;
          rsp_granted_d = res_granted_q;
          rsp_status_d  = res_status_q;
          rsp_free_d    = free_q;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Configuration writes
    if (cfg_i.valid) begin
      case (cfg_i.index)
        bfa_pkg::CFG_FRAMES: begin
          fiu_d  = cfg_i.data[CW-1:0];
          pend_d = 1'b1;
        end
        bfa_pkg::CFG_POLICY: begin
          dpol_d = cfg_i.data[1:0];
        end
        bfa_pkg::CFG_SEED: begin
          lfsr_d = (cfg_i.data == '0) ? bfa_pkg::RESET_SEED : cfg_i.data;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      op_q          <= OP_ALLOC;
      ptr_q         <= '0;
      pol_q         <= bfa_pkg::POL_FIRST;
      bitsel_q      <= '0;
      k_q           <= '0;
      acc_q         <= '0;
      free_q        <= bfa_pkg::RESET_FRAMES;
      lfsr_q        <= bfa_pkg::RESET_SEED;
      fiu_q         <= bfa_pkg::RESET_FRAMES;
      dpol_q        <= bfa_pkg::POL_FIRST;
      pend_q        <= 1'b0;
      res_frame_q   <= '0;
      res_granted_q <= 1'b0;
      res_status_q  <= bfa_pkg::STAT_OK;
      rsp_valid_q   <= 1'b0;
      rsp_frame_q   <= '0;
      rsp_granted_q <= 1'b0;
      rsp_status_q  <= bfa_pkg::STAT_OK;
      rsp_free_q    <= '0;
    end else begin
      state_q       <= state_d;
      op_q          <= op_d;
      ptr_q         <= ptr_d;
      pol_q         <= pol_d;
      bitsel_q      <= bitsel_d;
      k_q           <= k_d;
      acc_q         <= acc_d;
      free_q        <= free_d;
      lfsr_q        <= lfsr_d;
      fiu_q         <= fiu_d;
      dpol_q        <= dpol_d;
      pend_q        <= pend_d;
      res_frame_q   <= res_frame_d;
      res_granted_q <= res_granted_d;
      res_status_q  <= res_status_d;
      rsp_valid_q   <= rsp_valid_d;
      rsp_frame_q   <= rsp_frame_d;
      rsp_granted_q <= rsp_granted_d;
      rsp_status_q  <= rsp_status_d;
      rsp_free_q    <= rsp_free_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.frame_number = rsp_frame_q;
  assign rsp_o.granted      = rsp_granted_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.free_frames  = rsp_free_q;

endmodule
